### design/tpr_pkg.sv
// Shared types, constants and the divide-by-1000 digit step for the tooth-pulse RPM meter.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tpr_pkg;

	// Parameter defaults
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int STAMP_WIDTH_DEF = 32;
	localparam int RPM_WIDTH_DEF   = 40;
	localparam int QUEUE_DEPTH     = 2;

	// Fixed field widths
	localparam int OP_W       = 2;
	localparam int STAMP_IN_W = 32;
	localparam int CLK_HZ_W   = 30;
	localparam int TEETH_W    = 8;
	localparam int ALPHA_W    = 10;
	localparam int CFG_DATA_W = 30;
	localparam int CFG_IDX_W  = 2;

	// Arithmetic constants
	localparam int MILLI     = 1000;
	localparam int MILLI_W   = 10;
	localparam int RPM_SCALE = 60 * MILLI;
	localparam int SCALE_W   = 16;
	localparam int DIGIT_W   = 8;
	localparam logic [MILLI_W-1:0] MILLI_V = MILLI_W'(MILLI);

	// Register reset values
	localparam logic [CLK_HZ_W-1:0] CLOCK_HZ_RST = CLK_HZ_W'(1000000);
	localparam logic [TEETH_W-1:0]  TEETH_RST    = TEETH_W'(1);
	localparam logic [ALPHA_W-1:0]  ALPHA_RST    = ALPHA_W'(100);

	typedef enum logic [OP_W-1:0] {
		OP_PULSE   = 2'd0,
		OP_TICK    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLOCK_HZ = 2'd0,
		CFG_TEETH    = 2'd1,
		CFG_ALPHA    = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SCALE,
		BK_DIV,
		BK_FMUL,
		BK_FACC,
		BK_FDIV,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic [MILLI_W-1:0] rem;
		logic [DIGIT_W-1:0] q;
	} milli_step_t;

	// One digit of restoring division by 1000: DIGIT_W numerator bits in,
	// DIGIT_W quotient bits out. The remainder stays below 1000.
	function automatic milli_step_t milli_step(input logic [MILLI_W-1:0] rem_in,
			input logic [DIGIT_W-1:0] bits);
		logic [MILLI_W:0]   trial;
		logic [MILLI_W-1:0] r;
		milli_step_t        res;
		r = rem_in;
		res = '0;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			trial = {r, bits[i]};
			if (trial >= {1'b0, MILLI_V}) begin
				trial = trial - {1'b0, MILLI_V};
				res.q[i] = 1'b1;
			end else begin
				res.q[i] = 1'b0;
			end
			r = trial[MILLI_W-1:0];
		end
		res.rem = r;
		return res;
	endfunction

endpackage

`default_nettype wire

### design/tpr_in_if.sv
// Input channel: one beat carries an op code and a cycle stamp.
// Depends on tpr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tpr_in_if import tpr_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       op;
	logic [STAMP_IN_W-1:0] stamp;

	modport source (output valid, output op, output stamp, input ready);
	modport sink   (input valid, input op, input stamp, output ready);
endinterface

`default_nettype wire

### design/tpr_out_if.sv
// Output channel: one beat carries the filtered speed and the fault flag.
// Depends on tpr_pkg for the default speed width.
`timescale 1ns / 1ps
`default_nettype none

interface tpr_out_if import tpr_pkg::*; #(
	parameter int RPM_WIDTH = RPM_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic [RPM_WIDTH-1:0] rpm_milli;
	logic                 fault;

	modport source (output valid, output rpm_milli, output fault, input ready);
	modport sink   (input valid, input rpm_milli, input fault, output ready);
endinterface

`default_nettype wire

### design/tpr_front.sv
// Front end: accepts beats, keeps the pulse counter and reference stamp,
// and hands each sample tick to the back end as a job. Depends on tpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpr_front import tpr_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic [OP_W-1:0]        in_op,
	input  wire logic [STAMP_WIDTH-1:0] in_stamp,
	output logic                        in_ready,
	input  wire logic                   q_full,
	output logic                        push,
	output logic                        push_fault,
	output logic [COUNT_WIDTH-1:0]      push_count,
	output logic [STAMP_WIDTH-1:0]      push_elapsed
);

	logic [COUNT_WIDTH-1:0] count_q;
	logic [STAMP_WIDTH-1:0] ref_q;
	logic [STAMP_WIDTH-1:0] elapsed;
	logic                   accept;

	// A tick needs a queue slot; everything else waits with it to keep order
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign elapsed  = in_stamp - ref_q;

	assign push         = accept && (in_op == OP_TICK);
	assign push_fault   = (elapsed == '0);
	assign push_count   = count_q;
	assign push_elapsed = elapsed;

	// Counter and reference stamp update per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ref_q   <= '0;
		end else if (accept) begin
			unique case (in_op)
				OP_PULSE: begin
					if (count_q != '1)
						count_q <= count_q + COUNT_WIDTH'(1);
				end
				OP_TICK: begin
					// zero elapsed keeps both; the back end reports the fault
					if (elapsed != '0) begin
						count_q <= '0;
						ref_q   <= in_stamp;
					end
				end
				OP_RESTART: begin
					ref_q <= in_stamp;
				end
				default: begin
					// unused op code: no effect
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/tpr_fifo.sv
// Short job queue between the front and back ends.
// Depends on tpr_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module tpr_fifo import tpr_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	output logic                  rd_valid,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_rd)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

### design/tpr_div.sv
// Restoring divider, one quotient bit per cycle, for the raw speed.
// Depends on tpr_pkg only through the import convention.
`timescale 1ns / 1ps
`default_nettype none

module tpr_div import tpr_pkg::*; #(
	parameter int NUM_W = 62,
	parameter int DEN_W = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,   // held stable until done
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] nq_q;    // numerator bits shift out the top, quotient in the bottom
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = (trial >= {1'b0, den});
	assign done  = done_q;
	assign quot  = nq_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start)
				cnt_q <= CNT_W'(NUM_W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Shift and conditional subtract
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			nq_q  <= {nq_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

endmodule

`default_nettype wire

### design/tpr_back.sv
// Back end: turns a job into raw milli-RPM, applies the moving average and
// holds the result in an output register. Depends on tpr_pkg and tpr_div.
`timescale 1ns / 1ps
`default_nettype none

module tpr_back import tpr_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int STAMP_WIDTH = STAMP_WIDTH_DEF,
	parameter int RPM_WIDTH   = RPM_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_valid,
	input  wire logic                   job_fault,
	input  wire logic [COUNT_WIDTH-1:0] job_count,
	input  wire logic [STAMP_WIDTH-1:0] job_elapsed,
	output logic                        job_pop,
	input  wire logic [CLK_HZ_W-1:0]    clock_hz,
	input  wire logic [TEETH_W-1:0]     teeth,
	input  wire logic [ALPHA_W-1:0]     alpha,
	output logic                        out_valid,
	output logic [RPM_WIDTH-1:0]        out_rpm_milli,
	output logic                        out_fault,
	input  wire logic                   out_ready
);

	localparam int PROD_W    = COUNT_WIDTH + CLK_HZ_W;
	localparam int NUM_W     = PROD_W + SCALE_W;
	localparam int DEN_W     = STAMP_WIDTH + TEETH_W;
	localparam int SUM_W     = RPM_WIDTH + ALPHA_W;
	localparam int SUM_STEPS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W     = SUM_STEPS * DIGIT_W;
	localparam int FCNT_W    = $clog2(SUM_STEPS + 1);
	localparam logic [RPM_WIDTH-1:0] RPM_MAX = '1;

	back_state_t            state_q, state_d;
	logic [COUNT_WIDTH-1:0] jcnt_q;
	logic [STAMP_WIDTH-1:0] jel_q;
	logic                   res_fault_q;
	logic [PROD_W-1:0]      prod_q;
	logic [DEN_W-1:0]       den_q;
	logic [SUM_W-1:0]       acc_q;
	logic [PAD_W-1:0]       fq_q;
	logic [MILLI_W-1:0]     frem_q;
	logic [FCNT_W-1:0]      fcnt_q;
	logic [RPM_WIDTH-1:0]   filt_q;
	logic                   out_valid_q;
	logic [RPM_WIDTH-1:0]   out_rpm_q;
	logic                   out_fault_q;

	logic [TEETH_W-1:0]     teeth_eff;
	logic [ALPHA_W-1:0]     alpha_eff;
	logic [ALPHA_W-1:0]     alpha_inv;
	logic [NUM_W-1:0]       div_num;
	logic [NUM_W-1:0]       div_quot;
	logic                   div_done;
	logic                   div_start;
	logic [RPM_WIDTH-1:0]   raw;
	logic                   out_load;
	milli_step_t            fstep;

	// Register clean-up: zero teeth counts as one, alpha caps at 1000
	assign teeth_eff = (teeth == '0) ? TEETH_W'(1) : teeth;
	assign alpha_eff = (alpha > MILLI_V) ? MILLI_V : alpha;
	assign alpha_inv = MILLI_V - alpha_eff;

	assign div_num = NUM_W'(prod_q) * NUM_W'(RPM_SCALE);
	assign raw     = (div_quot[NUM_W-1:RPM_WIDTH] != '0) ? RPM_MAX
	                                                     : div_quot[RPM_WIDTH-1:0];
	assign fstep   = milli_step(frem_q, fq_q[PAD_W-1 -: DIGIT_W]);

	assign out_valid     = out_valid_q;
	assign out_rpm_milli = out_rpm_q;
	assign out_fault     = out_fault_q;

	tpr_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (job_valid) state_d = job_fault ? BK_OUT : BK_MUL;
			BK_MUL:   state_d = BK_SCALE;
			BK_SCALE: state_d = BK_DIV;
			BK_DIV:   if (div_done) state_d = BK_FMUL;
			BK_FMUL:  state_d = BK_FACC;
			BK_FACC:  state_d = BK_FDIV;
			BK_FDIV:  if (fcnt_q == '0) state_d = BK_OUT;
			BK_OUT:   if (out_load) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		job_pop   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE:  job_pop = job_valid;
			BK_SCALE: div_start = 1'b1;
			BK_OUT:   out_load = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	// Control state, filter memory and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			filt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_FDIV && fcnt_q == '0)
				filt_q <= fq_q[RPM_WIDTH-1:0];
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (job_pop) begin
			jcnt_q      <= job_count;
			jel_q       <= job_elapsed;
			res_fault_q <= job_fault;
		end
		if (out_load) begin
			out_rpm_q   <= filt_q;
			out_fault_q <= res_fault_q;
		end
		case (state_q)
			BK_MUL: begin
				prod_q <= PROD_W'(jcnt_q) * PROD_W'(clock_hz);
				den_q  <= DEN_W'(jel_q) * DEN_W'(teeth_eff);
			end
			BK_FMUL: begin
				acc_q <= SUM_W'(raw) * SUM_W'(alpha_eff);
			end
			BK_FACC: begin
				fq_q   <= PAD_W'(acc_q + SUM_W'(filt_q) * SUM_W'(alpha_inv));
				frem_q <= '0;
				fcnt_q <= FCNT_W'(SUM_STEPS);
			end
			BK_FDIV: begin
				if (fcnt_q != '0) begin
					fq_q   <= {fq_q[PAD_W-DIGIT_W-1:0], fstep.q};
					frem_q <= fstep.rem;
					fcnt_q <= fcnt_q - FCNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### design/tooth_pulse_rpm_meter.sv
// Tooth-pulse RPM meter. Pulse and restart beats are taken one per cycle while the job queue
// has room. A sample tick yields one result after the multiply, scale, divide and filter steps,
// with the divider taking one quotient bit per cycle (NUM_W = COUNT_WIDTH + 46); a zero-elapsed
// tick skips those steps and goes straight to the output register. One tick is processed at a time.
// Reset (arst_n low) clears count, reference stamp, filter and queue, and loads the register
// defaults: 1 MHz stamp clock, one tooth, alpha 100.
`timescale 1ns / 1ps
`default_nettype none

module tooth_pulse_rpm_meter import tpr_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int STAMP_WIDTH = STAMP_WIDTH_DEF,
	parameter int RPM_WIDTH   = RPM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tpr_in_if.sink                     in_ch,
	tpr_out_if.source                  out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int JOB_W = 1 + COUNT_WIDTH + STAMP_WIDTH;

	logic [CLK_HZ_W-1:0]    clock_hz_q;
	logic [TEETH_W-1:0]     teeth_q;
	logic [ALPHA_W-1:0]     alpha_q;

	logic                   q_full;
	logic                   push;
	logic                   push_fault;
	logic [COUNT_WIDTH-1:0] push_count;
	logic [STAMP_WIDTH-1:0] push_elapsed;
	logic                   job_valid;
	logic                   job_pop;
	logic [JOB_W-1:0]       job_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_HZ_RST;
			teeth_q    <= TEETH_RST;
			alpha_q    <= ALPHA_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CLOCK_HZ: clock_hz_q <= cfg_wdata[CLK_HZ_W-1:0];
				CFG_TEETH:    teeth_q    <= cfg_wdata[TEETH_W-1:0];
				CFG_ALPHA:    alpha_q    <= cfg_wdata[ALPHA_W-1:0];
				default: begin
					// no register at this index
				end
			endcase
		end
	end

	tpr_front #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_op        (in_ch.op),
		.in_stamp     (in_ch.stamp[STAMP_WIDTH-1:0]),
		.in_ready     (in_ch.ready),
		.q_full       (q_full),
		.push         (push),
		.push_fault   (push_fault),
		.push_count   (push_count),
		.push_elapsed (push_elapsed)
	);

	tpr_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  ({push_fault, push_count, push_elapsed}),
		.full     (q_full),
		.rd_valid (job_valid),
		.rd_en    (job_pop),
		.rd_data  (job_data)
	);

	tpr_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.STAMP_WIDTH (STAMP_WIDTH),
		.RPM_WIDTH   (RPM_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job_fault     (job_data[JOB_W-1]),
		.job_count     (job_data[JOB_W-2 -: COUNT_WIDTH]),
		.job_elapsed   (job_data[STAMP_WIDTH-1:0]),
		.job_pop       (job_pop),
		.clock_hz      (clock_hz_q),
		.teeth         (teeth_q),
		.alpha         (alpha_q),
		.out_valid     (out_ch.valid),
		.out_rpm_milli (out_ch.rpm_milli),
		.out_fault     (out_ch.fault),
		.out_ready     (out_ch.ready)
	);

endmodule

`default_nettype wire
